>>> hw/rtl/dhb_pkg.sv
// Package for the dual H-bridge PWM block with sensor filter.
// Holds the beat payload types, register indexes and widths.
// It has no dependencies and is compiled first.
`timescale 1ns / 1ps

package dhb_pkg;

	localparam int PWM_PERIOD = 100;
	localparam int DUTY_MAX   = 100;

	localparam int PHASE_W  = 7;
	localparam int COUNT_W  = 16;
	localparam int SAMPLE_W = 7;
	localparam int DUTY_W   = 8;
	localparam int MAG_W    = 7;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DUTY_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_DUTY  = 1'b0,
		REG_RIGHT_DUTY = 1'b1
	} cfg_reg_t;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t front_sample;
		sample_t back_sample;
		logic    brake_timing;
	} tick_t;

	typedef struct packed {
		logic               left_forward;
		logic               left_reverse;
		logic               right_forward;
		logic               right_reverse;
		sample_t            front_filtered;
		sample_t            back_filtered;
		logic [COUNT_W-1:0] periods_counted;
	} result_t;

	// Clamp a written duty value to the range -DUTY_MAX..DUTY_MAX.
	function automatic logic signed [DUTY_W-1:0] sat_duty(
		input logic signed [DUTY_W-1:0] value
	);
		logic signed [DUTY_W-1:0] lim;
		lim = DUTY_W'(DUTY_MAX);
		if (value > lim) begin
			return lim;
		end else if (value < -lim) begin
			return -lim;
		end
		return value;
	endfunction

	// Bitwise majority of three samples.
	function automatic sample_t majority(input sample_t a, input sample_t b, input sample_t c);
		return (b & (a | c)) | (a & c);
	endfunction

endpackage

>>> hw/rtl/dhb_if.sv
// Valid/ready channel interfaces for the tick and result beats.
// Depends on dhb_pkg for the payload types.
`timescale 1ns / 1ps

interface dhb_tick_if
	import dhb_pkg::*;
();
	logic  valid;
	logic  ready;
	tick_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dhb_result_if
	import dhb_pkg::*;
();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/dual_h_bridge_pwm_with_sensor_filter_top.sv
// Top level: signed PWM drive for two H-bridge sides and sensor majority filter.
// Depends on dhb_pkg and the channel interfaces in dhb_if.sv.
// An accepted tick beat is registered as its result beat in the output register;
// one beat per cycle passes while result is ready, set by that single register.
// The tick channel is ready whenever the output register is empty or being drained.
// Reset clears the phase, the period count, the sample history and both duties.
`timescale 1ns / 1ps

module dual_h_bridge_pwm_with_sensor_filter_top
	import dhb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	dhb_tick_if.sink              tick,
	dhb_result_if.source          result
);

	logic signed [DUTY_W-1:0] left_duty_q;
	logic signed [DUTY_W-1:0] right_duty_q;
	logic [PHASE_W-1:0]       phase_q;
	logic [COUNT_W-1:0]       count_q;
	sample_t                  front_hist_q [2];
	sample_t                  back_hist_q [2];

	logic    res_valid_s1;
	result_t res_s1;

	logic               accept;
	logic [PHASE_W:0]   phase_inc;
	logic               wrap;
	logic [PHASE_W-1:0] phase_next;
	logic [COUNT_W-1:0] count_base;
	logic [COUNT_W-1:0] count_next;
	logic [MAG_W-1:0]   left_mag;
	logic [MAG_W-1:0]   right_mag;
	logic               left_hit;
	logic               right_hit;
	result_t            res_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_duty_q  <= '0;
			right_duty_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEFT_DUTY:  left_duty_q  <= sat_duty(cfg_wdata);
				REG_RIGHT_DUTY: right_duty_q <= sat_duty(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign tick.ready = !res_valid_s1 || result.ready;
	assign accept     = tick.valid && tick.ready;

	always_comb begin
		phase_inc  = {1'b0, phase_q} + (PHASE_W+1)'(1);
		wrap       = phase_inc >= (PHASE_W+1)'(PWM_PERIOD);
		phase_next = wrap ? '0 : phase_inc[PHASE_W-1:0];

		count_base = tick.payload.brake_timing ? count_q : '0;
		count_next = (wrap && tick.payload.brake_timing) ?
			count_base + COUNT_W'(1) : count_base;

		left_mag  = left_duty_q[DUTY_W-1] ? MAG_W'(-left_duty_q) : MAG_W'(left_duty_q);
		right_mag = right_duty_q[DUTY_W-1] ? MAG_W'(-right_duty_q) : MAG_W'(right_duty_q);
		left_hit  = phase_next < left_mag;
		right_hit = phase_next < right_mag;

		res_next.left_forward    = left_hit && !left_duty_q[DUTY_W-1];
		res_next.left_reverse    = left_hit && left_duty_q[DUTY_W-1];
		res_next.right_forward   = right_hit && !right_duty_q[DUTY_W-1];
		res_next.right_reverse   = right_hit && right_duty_q[DUTY_W-1];
		res_next.front_filtered  = majority(front_hist_q[0], front_hist_q[1],
			tick.payload.front_sample);
		res_next.back_filtered   = majority(back_hist_q[0], back_hist_q[1],
			tick.payload.back_sample);
		res_next.periods_counted = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= '0;
			count_q        <= '0;
			front_hist_q[0] <= '0;
			front_hist_q[1] <= '0;
			back_hist_q[0]  <= '0;
			back_hist_q[1]  <= '0;
		end else if (accept) begin
			phase_q         <= phase_next;
			count_q         <= count_next;
			front_hist_q[0] <= front_hist_q[1];
			front_hist_q[1] <= tick.payload.front_sample;
			back_hist_q[0]  <= back_hist_q[1];
			back_hist_q[1]  <= tick.payload.back_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			res_valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_next;
		end
	end

	assign result.valid   = res_valid_s1;
	assign result.payload = res_s1;

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PHASE_W'(PWM_PERIOD))
		else $error("phase left the PWM period");

	a_no_shoot_through: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.payload.left_forward && result.payload.left_reverse) &&
			!(result.payload.right_forward && result.payload.right_reverse))
		else $error("both drive directions active on one side");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !tick.payload.brake_timing |=> result.payload.periods_counted == '0)
		else $error("period count not cleared without brake timing");

	a_beat_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid)
		else $error("accepted tick produced no result beat");

endmodule
